// ===== rtl/core/dlr_pkg.sv =====
// Package for the dense label relabel block: sizes, transaction payload types,
// map table entry layout and the clearing-pass state type. No dependencies.
package dlr_pkg;

    localparam int MAX_LABELS = 4096;
    localparam int LBL_W      = $clog2(MAX_LABELS);
    localparam int CNT_W      = LBL_W + 1;
    localparam int EPOCH_W    = 8;

    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef struct packed {
        logic [15:0] pixel_label;
        logic        frame_start;
    } t_in;

    typedef struct packed {
        logic [11:0] dense_label;
        logic        new_region;
        logic [12:0] region_count;
        logic        label_error;
    } t_out;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [LBL_W-1:0]   id;
    } t_map_entry;

    localparam int ENTRY_W = $bits(t_map_entry);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_sweep_state;

endpackage

// ===== rtl/core/dlr_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the label map table of the relabel block. No package dependencies.
module dlr_ram #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 20
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dense_label_relabel_top.sv =====
// Top level of the dense label relabel block: epoch-tagged map table, lookup
// pipeline with write forwarding, and output register. Uses dlr_pkg and dlr_ram.
// Results pass stage one, then the output register; throughput 1 pixel per cycle when unstalled.
// The throughput is set by the single read and write port of the map table.
// After reset a clearing pass writes all MAX_LABELS (4096) entries before input is taken.
// The same pass runs again at most once every 254 frame starts, when the epoch wraps.
module dense_label_relabel_top
    import dlr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    t_sweep_state r_state, n_state;
    logic [LBL_W-1:0]   r_sweep_addr;
    logic               sweep_done;

    logic [EPOCH_W-1:0] r_epoch;
    logic [LBL_W:0]     r_next_id;

    logic               r_s1_valid;
    logic [LBL_W-1:0]   r_s1_addr;
    logic               r_s1_start;
    logic               r_s1_err;

    logic               r_fwd_valid;
    logic [LBL_W-1:0]   r_fwd_addr;
    t_map_entry         r_fwd_entry;

    logic               r_out_valid;
    t_out               r_out_data;

    logic               in_accept;
    logic               s1_adv;
    logic               s1_free;
    logic               wrap_hold;
    logic [EPOCH_W-1:0] epoch_after;
    logic [EPOCH_W-1:0] epoch_use;
    logic [LBL_W:0]     base_id;
    logic               in_err;

    t_map_entry         rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic               fwd_hit;
    logic               mem_hit;
    logic               fresh;
    logic [LBL_W-1:0]   hit_id;
    logic [LBL_W-1:0]   res_id;
    logic [LBL_W:0]     res_count;

    logic               ram_wr_en;
    logic [LBL_W-1:0]   ram_wr_addr;
    t_map_entry         ram_wr_entry;
    t_map_entry         new_entry;

    // Pipeline control.
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_free     = !r_s1_valid || s1_adv;
    assign epoch_after = (s1_adv && r_s1_start) ? r_epoch + EPOCH_W'(1) : r_epoch;
    assign wrap_hold   = i_in_valid && i_in_data.frame_start && (epoch_after == EPOCH_LAST);
    assign o_in_stall  = (r_state != ST_IDLE) || !s1_free || wrap_hold;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_err      = {1'b0, i_in_data.pixel_label} >= 17'(MAX_LABELS);
    assign sweep_done  = (r_sweep_addr == LBL_W'(MAX_LABELS - 1));

    // Clearing pass state machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (wrap_hold && !r_s1_valid) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
        end else if (r_state == ST_SWEEP) begin
            r_sweep_addr <= sweep_done ? '0 : r_sweep_addr + LBL_W'(1);
        end
    end

    // Lookup resolution from the stage one registers and the table read.
    assign rd_entry  = t_map_entry'(rd_data);
    assign epoch_use = r_s1_start ? r_epoch + EPOCH_W'(1) : r_epoch;
    assign base_id   = r_s1_start ? '0 : r_next_id;
    assign fwd_hit   = r_fwd_valid && (r_fwd_addr == r_s1_addr) && (r_fwd_entry.tag == epoch_use);
    assign mem_hit   = (rd_entry.tag == epoch_use);
    assign hit_id    = fwd_hit ? r_fwd_entry.id : rd_entry.id;
    assign fresh     = !r_s1_err && !fwd_hit && !mem_hit;
    assign res_id    = r_s1_err ? '0 : (fresh ? base_id[LBL_W-1:0] : hit_id);
    assign res_count = base_id + (LBL_W+1)'(fresh);

    assign new_entry.tag = epoch_use;
    assign new_entry.id  = base_id[LBL_W-1:0];

    always_comb begin
        if (r_state == ST_SWEEP) begin
            ram_wr_en        = 1'b1;
            ram_wr_addr      = r_sweep_addr;
            ram_wr_entry.tag = EPOCH_NONE;
            ram_wr_entry.id  = '0;
        end else begin
            ram_wr_en    = s1_adv && fresh;
            ram_wr_addr  = r_s1_addr;
            ram_wr_entry = new_entry;
        end
    end

    dlr_ram #(
        .ADDR_W (LBL_W),
        .DEPTH  (MAX_LABELS),
        .DATA_W (ENTRY_W)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ENTRY_W'(ram_wr_entry)),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_in_data.pixel_label[LBL_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Stage one and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr  <= i_in_data.pixel_label[LBL_W-1:0];
            r_s1_start <= i_in_data.frame_start;
            r_s1_err   <= in_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch   <= EPOCH_FIRST;
            r_next_id <= '0;
        end else if (r_state == ST_SWEEP) begin
            if (sweep_done) begin
                r_epoch <= EPOCH_FIRST;
            end
        end else if (s1_adv) begin
            r_epoch   <= epoch_use;
            r_next_id <= res_count;
        end
    end

    // The last table write, for a lookup issued in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (r_state == ST_SWEEP) begin
            r_fwd_valid <= 1'b0;
        end else if (s1_adv && fresh) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && fresh) begin
            r_fwd_addr  <= r_s1_addr;
            r_fwd_entry <= new_entry;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data.dense_label  <= 12'(res_id);
            r_out_data.new_region   <= fresh;
            r_out_data.region_count <= 13'(res_count);
            r_out_data.label_error  <= r_s1_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The clearing pass never overlaps a transaction in flight.
    a_sweep_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (!r_s1_valid && !in_accept))
        else $error("transaction in flight during clearing pass");

    // An idle table always runs under a live epoch.
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_epoch != EPOCH_NONE))
        else $error("idle with the invalid epoch");

    // A new region advances the counter by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && fresh) |=> (r_next_id == $past(base_id) + (LBL_W+1)'(1)))
        else $error("region counter did not step by one");

    // An out of range label never writes the table.
    a_err_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && s1_adv && r_s1_err) |-> !ram_wr_en)
        else $error("table written for an out of range label");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for dense_label_relabel_top: sends pixel label streams through the
// valid/stall channels and checks every result against a local first-appearance map.
// Depends on dlr_pkg and the RTL of dense_label_relabel_top.
`timescale 1ns / 1ps

module tb_top;
    import dlr_pkg::*;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    logic        label_seen [MAX_LABELS];
    logic [11:0] label_id   [MAX_LABELS];
    logic [12:0] region_total;

    t_out expected_pixels [$];
    int   fail_count    = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_req      = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;

    dense_label_relabel_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void clear_label_map();
        foreach (label_seen[k]) begin
            label_seen[k] = 1'b0;
            label_id[k]   = '0;
        end
        region_total = '0;
    endfunction

    function automatic t_out compact_label(input t_in px);
        t_out             res;
        logic [LBL_W-1:0] idx;
        res = '0;
        idx = px.pixel_label[LBL_W-1:0];
        if (px.frame_start)
            clear_label_map();
        if (int'(px.pixel_label) >= MAX_LABELS) begin
            res.label_error = 1'b1;
        end else if (!label_seen[idx]) begin
            label_seen[idx] = 1'b1;
            label_id[idx]   = region_total[11:0];
            res.dense_label = region_total[11:0];
            res.new_region  = 1'b1;
            region_total    = region_total + 13'd1;
        end else begin
            res.dense_label = label_id[idx];
        end
        res.region_count = region_total;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic report_field(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         o_out_data);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.dense_label !== want.dense_label)
                    report_field("dense_label", int'(want.dense_label),
                                 int'(o_out_data.dense_label));
                if (o_out_data.new_region !== want.new_region)
                    report_field("new_region", int'(want.new_region),
                                 int'(o_out_data.new_region));
                if (o_out_data.region_count !== want.region_count)
                    report_field("region_count", int'(want.region_count),
                                 int'(o_out_data.region_count));
                if (o_out_data.label_error !== want.label_error)
                    report_field("label_error", int'(want.label_error),
                                 int'(o_out_data.label_error));
            end
        end
    end

    task automatic send_pixel(input logic [15:0] label, input logic start);
        int  gap;
        t_in px;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        px.pixel_label = label;
        px.frame_start = start;
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        expected_pixels.push_back(compact_label(px));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd4095, 1'b0);
        send_pixel(16'd4096, 1'b0);
        send_pixel(16'd65535, 1'b0);
        send_pixel(16'd4095, 1'b0);
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd0, 1'b1);
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd4095, 1'b0);
        send_pixel(16'd65535, 1'b1);
        send_pixel(16'd1, 1'b0);
        send_pixel(16'd2, 1'b0);
        send_pixel(16'd1, 1'b0);
        send_pixel(16'd2, 1'b0);
        send_pixel(16'd32768, 1'b0);
        send_pixel(16'd2, 1'b1);
        send_pixel(16'd2, 1'b1);
        send_pixel(16'd3, 1'b0);
        send_pixel(16'd43690, 1'b0);
        send_pixel(16'd21845, 1'b0);
        send_pixel(16'd2730, 1'b0);
        send_pixel(16'd1365, 1'b0);
        drain_results();
    endtask

    task automatic test_frame_storm();
        int n_extra;
        send_idle_pct = 26;
        recv_idle_pct = 47;
        for (int f = 0; f < 280; f++) begin
            send_pixel(16'($urandom_range(7)), 1'b1);
            n_extra = $urandom_range(1);
            for (int p = 0; p < n_extra; p++)
                send_pixel(16'($urandom_range(7)), 1'b0);
        end
        drain_results();
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        for (int k = 0; k < 60; k++)
            send_pixel(16'($urandom_range(15)), k == 0);
        drain_results();
    endtask

    task automatic test_random_frames(input int n_items, input int send_pct,
                                      input int recv_pct);
        logic [15:0] pool [32];
        logic [15:0] cur;
        int          sent;
        int          pool_n;
        int          frame_len;
        int          run_left;
        int          r;
        logic        starts;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        cur  = '0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 3)
                drain_results();
            pool_n = $urandom_range(1, 32);
            foreach (pool[k])
                pool[k] = 16'($urandom_range(MAX_LABELS - 1));
            frame_len = $urandom_range(10, 80);
            starts    = ($urandom_range(99) < 85);
            run_left  = 0;
            for (int p = 0; p < frame_len && sent < n_items; p++) begin
                if (run_left == 0) begin
                    r = $urandom_range(99);
                    if (r < 8)
                        cur = 16'($urandom_range(MAX_LABELS, 65535));
                    else if (r < 18)
                        cur = 16'($urandom_range(MAX_LABELS - 1));
                    else
                        cur = pool[$urandom_range(pool_n - 1)];
                    run_left = $urandom_range(1, 6);
                end
                send_pixel(cur, (starts && p == 0) || $urandom_range(199) == 0);
                run_left--;
                sent++;
            end
        end
        drain_results();
    endtask

    initial begin
        clear_label_map();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_frame_storm();
        test_output_hold();
        test_random_frames(280, 26, 47);
        test_random_frames(280, 47, 26);
        test_random_frames(280, 0, 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dlr_pkg.sv
rtl/core/dlr_ram.sv
rtl/core/dense_label_relabel_top.sv
bench/tb_top.sv
